FILE: hw/rtl/pcru_pkg.sv
// Package: transaction types, decode codes and commands for the PMMU control register unit.
package pcru_pkg;

    // Input transaction payload
    typedef struct packed {
        logic [15:0] ext_word;
        logic [31:0] operand_hi;
        logic [31:0] operand_lo;
        logic        operand_fault;
    } t_in;

    // Result transaction payload
    typedef struct packed {
        logic [2:0]  status;
        logic [1:0]  store_kind;
        logic [31:0] store_hi;
        logic [31:0] store_lo;
        logic        flush_atc;
        logic        translation_enabled;
    } t_out;

    typedef enum logic [2:0] {
        ST_DONE   = 3'd0,
        ST_FLINE  = 3'd1,
        ST_CONFIG = 3'd2,
        ST_FAULT  = 3'd3,
        ST_WALK   = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        SK_NONE = 2'd0,
        SK_LONG = 2'd1,
        SK_TWO  = 2'd2,
        SK_WORD = 2'd3
    } t_store_kind;

    // Extension word op field
    typedef enum logic [2:0] {
        OP_PMOVE_TT  = 3'd0,
        OP_PFLUSH    = 3'd1,
        OP_PMOVE_MMU = 3'd2,
        OP_PMOVE_SR  = 3'd3,
        OP_PTEST     = 3'd4
    } t_op;

    // Register select codes
    localparam logic [2:0] REG_TC  = 3'd0;
    localparam logic [2:0] REG_TT0 = 3'd2;
    localparam logic [2:0] REG_TT1 = 3'd3;
    localparam logic [2:0] REG_SRP = 3'd2;
    localparam logic [2:0] REG_CRP = 3'd3;

    // PLOAD/PFLUSH mode codes
    localparam logic [2:0] MODE_PLOAD     = 3'd0;
    localparam logic [2:0] MODE_FLUSH_ALL = 3'd1;
    localparam logic [2:0] MODE_FLUSH_FC  = 3'd4;
    localparam logic [2:0] MODE_FLUSH_EA  = 3'd6;

    // TC field checks
    localparam logic [6:0] TC_FIELD_SUM = 7'd32;
    localparam logic [3:0] TC_PS_MIN    = 4'd8;
    localparam logic [1:0] DT_INVALID   = 2'd0;

    // Work that the back end carries out
    typedef enum logic [4:0] {
        ACT_NONE,
        ACT_FLINE,
        ACT_WALK,
        ACT_FLUSH,
        ACT_FAULT,
        ACT_LD_TT0,
        ACT_LD_TT1,
        ACT_ST_TT0,
        ACT_ST_TT1,
        ACT_LD_TC,
        ACT_ST_TC,
        ACT_LD_SRP,
        ACT_LD_CRP,
        ACT_ST_SRP,
        ACT_ST_CRP,
        ACT_LD_SR,
        ACT_ST_SR
    } t_action;

    // Classified command held in the queue
    typedef struct packed {
        t_action     action;
        logic        fd;
        logic        tc_config;
        logic        root_invalid;
        logic [31:0] data_hi;
        logic [31:0] data_lo;
    } t_cmd;

endpackage

FILE: hw/rtl/pcru_front.sv
// Front end: decodes the extension word and operand checks into a command.
module pcru_front (
    input  pcru_pkg::t_in  i_item,
    output pcru_pkg::t_cmd o_cmd
);
    import pcru_pkg::*;

    logic [2:0] op;
    logic [2:0] sel;
    logic       to_mem;
    logic       load_ok;
    logic [3:0] ps;
    logic [6:0] field_sum;
    t_action    action;

    assign op      = i_item.ext_word[15:13];
    assign sel     = i_item.ext_word[12:10];
    assign to_mem  = i_item.ext_word[9];
    assign load_ok = !i_item.operand_fault;
    assign ps      = i_item.operand_hi[23:20];

    // TC field sum: IS + PS + TIA + TIB + TIC + TID
    assign field_sum = 7'(i_item.operand_hi[19:16]) + 7'(ps)
                     + 7'(i_item.operand_hi[15:12]) + 7'(i_item.operand_hi[11:8])
                     + 7'(i_item.operand_hi[7:4])   + 7'(i_item.operand_hi[3:0]);

    // Classify the instruction
    always_comb begin
        action = ACT_NONE;
        case (op)
            OP_PMOVE_TT: begin
                if (sel == REG_TT0 || sel == REG_TT1) begin
                    if (to_mem) begin
                        action = (sel == REG_TT0) ? ACT_ST_TT0 : ACT_ST_TT1;
                    end else if (!load_ok) begin
                        action = ACT_FAULT;
                    end else begin
                        action = (sel == REG_TT0) ? ACT_LD_TT0 : ACT_LD_TT1;
                    end
                end
            end
            OP_PFLUSH: begin
                if (sel == MODE_PLOAD) begin
                    action = ACT_WALK;
                end else if (sel inside {MODE_FLUSH_ALL, MODE_FLUSH_FC, MODE_FLUSH_EA}) begin
                    action = ACT_FLUSH;
                end else begin
                    action = ACT_FLINE;
                end
            end
            OP_PMOVE_MMU: begin
                if (sel == REG_TC) begin
                    if (to_mem)        action = ACT_ST_TC;
                    else if (!load_ok) action = ACT_FAULT;
                    else               action = ACT_LD_TC;
                end else if (sel == REG_SRP || sel == REG_CRP) begin
                    if (to_mem) begin
                        action = (sel == REG_SRP) ? ACT_ST_SRP : ACT_ST_CRP;
                    end else if (!load_ok) begin
                        action = ACT_FAULT;
                    end else begin
                        action = (sel == REG_SRP) ? ACT_LD_SRP : ACT_LD_CRP;
                    end
                end
            end
            // MMUSR load ignores a fetch fault
            OP_PMOVE_SR: begin
                action = to_mem ? ACT_ST_SR : ACT_LD_SR;
            end
            OP_PTEST: begin
                action = ACT_WALK;
            end
            default: begin
                action = ACT_NONE;
            end
        endcase
    end

    // Command fields
    always_comb begin
        o_cmd.action       = action;
        o_cmd.fd           = i_item.ext_word[8];
        o_cmd.tc_config    = i_item.operand_hi[31]
                           && (field_sum != TC_FIELD_SUM || ps < TC_PS_MIN);
        o_cmd.root_invalid = (i_item.operand_hi[1:0] == DT_INVALID);
        o_cmd.data_hi      = i_item.operand_hi;
        o_cmd.data_lo      = i_item.operand_lo;
    end

endmodule

FILE: hw/rtl/pcru_queue.sv
// Two-entry command queue between front end and back end.
module pcru_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  pcru_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output pcru_pkg::t_cmd o_cmd
);
    import pcru_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic       n_wptr;
    logic       n_rptr;
    logic [1:0] n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_mem[r_rptr];

    // Pointer and fill count update
    always_comb begin
        n_wptr  = r_wptr ^ i_push;
        n_rptr  = r_rptr ^ i_pop;
        n_count = r_count + 2'(i_push) - 2'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

endmodule

FILE: hw/rtl/pcru_back.sv
// Back end: MMU register file, command execution and result register.
module pcru_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    input  pcru_pkg::t_cmd i_cmd,
    output logic           o_cmd_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output pcru_pkg::t_out o_data
);
    import pcru_pkg::*;

    logic [31:0] r_tc;
    logic        r_en;
    logic [63:0] r_srp;
    logic [63:0] r_crp;
    logic [31:0] r_tt0;
    logic [31:0] r_tt1;
    logic [15:0] r_mmusr;
    logic        r_out_valid;
    t_out        r_out;

    logic [31:0] n_tc;
    logic        n_en;
    logic [63:0] n_srp;
    logic [63:0] n_crp;
    logic [31:0] n_tt0;
    logic [31:0] n_tt1;
    logic [15:0] n_mmusr;
    t_out        n_out;
    logic        exec;

    // Take a command when the result register is free or being drained
    assign exec      = i_cmd_valid && (!r_out_valid || i_ready);
    assign o_cmd_pop = exec;
    assign o_valid   = r_out_valid;
    assign o_data    = r_out;

    // Execute one command
    always_comb begin
        n_tc    = r_tc;
        n_en    = r_en;
        n_srp   = r_srp;
        n_crp   = r_crp;
        n_tt0   = r_tt0;
        n_tt1   = r_tt1;
        n_mmusr = r_mmusr;
        n_out   = '0;
        case (i_cmd.action)
            ACT_FLINE: n_out.status = ST_FLINE;
            ACT_WALK:  n_out.status = ST_WALK;
            ACT_FAULT: n_out.status = ST_FAULT;
            ACT_FLUSH: n_out.flush_atc = 1'b1;
            ACT_LD_TT0: begin
                n_tt0           = i_cmd.data_hi;
                n_out.flush_atc = 1'b1;
            end
            ACT_LD_TT1: begin
                n_tt1           = i_cmd.data_hi;
                n_out.flush_atc = 1'b1;
            end
            ACT_ST_TT0: begin
                n_out.store_kind = SK_LONG;
                n_out.store_hi   = r_tt0;
            end
            ACT_ST_TT1: begin
                n_out.store_kind = SK_LONG;
                n_out.store_hi   = r_tt1;
            end
            // Bad TC layout still commits but drops the enable
            ACT_LD_TC: begin
                n_tc            = i_cmd.data_hi;
                n_en            = i_cmd.data_hi[31] && !i_cmd.tc_config;
                n_out.status    = i_cmd.tc_config ? ST_CONFIG : ST_DONE;
                n_out.flush_atc = i_cmd.tc_config || !i_cmd.fd;
            end
            ACT_ST_TC: begin
                n_out.store_kind = SK_LONG;
                n_out.store_hi   = r_tc;
            end
            ACT_LD_SRP, ACT_LD_CRP: begin
                if (i_cmd.action == ACT_LD_SRP) n_srp = {i_cmd.data_hi, i_cmd.data_lo};
                else                            n_crp = {i_cmd.data_hi, i_cmd.data_lo};
                n_out.status    = i_cmd.root_invalid ? ST_CONFIG : ST_DONE;
                n_out.flush_atc = i_cmd.root_invalid || !i_cmd.fd;
            end
            ACT_ST_SRP: begin
                n_out.store_kind = SK_TWO;
                n_out.store_hi   = r_srp[63:32];
                n_out.store_lo   = r_srp[31:0];
            end
            ACT_ST_CRP: begin
                n_out.store_kind = SK_TWO;
                n_out.store_hi   = r_crp[63:32];
                n_out.store_lo   = r_crp[31:0];
            end
            ACT_LD_SR: n_mmusr = i_cmd.data_hi[15:0];
            ACT_ST_SR: begin
                n_out.store_kind = SK_WORD;
                n_out.store_hi   = {16'd0, r_mmusr};
            end
            default: begin
                n_out.status = ST_DONE;
            end
        endcase
        n_out.translation_enabled = n_en;
    end

    // Architectural registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tc    <= '0;
            r_en    <= 1'b0;
            r_srp   <= '0;
            r_crp   <= '0;
            r_tt0   <= '0;
            r_tt1   <= '0;
            r_mmusr <= '0;
        end else if (exec) begin
            r_tc    <= n_tc;
            r_en    <= n_en;
            r_srp   <= n_srp;
            r_crp   <= n_crp;
            r_tt0   <= n_tt0;
            r_tt1   <= n_tt1;
            r_mmusr <= n_mmusr;
        end
    end

    // Result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (exec) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (exec) begin
            r_out <= n_out;
        end
    end

endmodule

FILE: hw/rtl/pmmu_control_register_unit.sv
// Top level of the PMMU control register unit: front end, command queue, back end.
//
//   Channel  Direction  Handshake           Payload
//   in       input      i_valid / o_ready   i_data  (pcru_pkg::t_in)
//   out      output     o_valid / i_ready   o_data  (pcru_pkg::t_out)
//
// One instruction per cycle sustained while the output is not stalled; an input
// transaction reaches the result through a queue entry, then the result register.
// The two-entry queue lets the front accept while the result register is held.
// Reset (synchronous, active low) clears all MMU registers, the queue and the result valid.
// A stalled output backs up into the queue; o_ready drops only when it is full.
module pmmu_control_register_unit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  pcru_pkg::t_in    i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output pcru_pkg::t_out   o_data
);
    import pcru_pkg::*;

    t_cmd front_cmd;
    t_cmd queue_cmd;
    logic queue_full;
    logic queue_valid;
    logic queue_pop;
    logic push;

    assign o_ready = !queue_full;
    assign push    = i_valid && !queue_full;

    pcru_front u_front (
        .i_item (i_data),
        .o_cmd  (front_cmd)
    );

    pcru_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (queue_full),
        .i_pop   (queue_pop),
        .o_valid (queue_valid),
        .o_cmd   (queue_cmd)
    );

    pcru_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (queue_valid),
        .i_cmd       (queue_cmd),
        .o_cmd_pop   (queue_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data)
    );

endmodule

FILE: tb/pcru_result_checker.sv
// Checker for the PMMU control register unit: watches both channels, predicts and compares.
`timescale 1ns / 100ps

module pcru_result_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_ready,
    input  pcru_pkg::t_in  i_in_data,
    input  logic           i_out_valid,
    input  logic           i_out_ready,
    input  pcru_pkg::t_out i_out_data,
    output int             o_fail_count,
    output int             o_pending
);
    import pcru_pkg::*;

    // Shadow copy of the MMU registers
    logic [31:0] tc_shadow;
    logic        enable_shadow;
    logic [63:0] srp_shadow;
    logic [63:0] crp_shadow;
    logic [31:0] tt0_shadow;
    logic [31:0] tt1_shadow;
    logic [15:0] mmusr_shadow;

    t_out expected_results[$];
    int   mismatch_count = 0;
    int   result_index   = 0;
    int   pending_count  = 0;

    assign o_fail_count = mismatch_count;
    assign o_pending    = pending_count;

    // One line per mismatch
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        $display("checker: result %0d %s got %h want %h", result_index, what, got, want);
    endtask

    // Executes one instruction on the shadow registers and returns its outcome
    function automatic t_out execute_instr(input t_in item);
        t_out        res;
        logic [2:0]  op;
        logic [2:0]  sel;
        logic        to_mem;
        logic        fd;
        logic        fault;
        logic [31:0] hi;
        logic [31:0] lo;
        logic [6:0]  field_sum;
        res        = '0;
        op         = item.ext_word[15:13];
        sel        = item.ext_word[12:10];
        to_mem     = item.ext_word[9];
        fd         = item.ext_word[8];
        fault      = item.operand_fault;
        hi         = item.operand_hi;
        lo         = item.operand_lo;
        res.status     = ST_DONE;
        res.store_kind = SK_NONE;
        case (op)
            OP_PMOVE_TT: begin
                if (sel == REG_TT0 || sel == REG_TT1) begin
                    if (to_mem) begin
                        res.store_kind = SK_LONG;
                        res.store_hi   = (sel == REG_TT0) ? tt0_shadow : tt1_shadow;
                    end else if (fault) begin
                        res.status = ST_FAULT;
                    end else begin
                        if (sel == REG_TT0) tt0_shadow = hi;
                        else tt1_shadow = hi;
                        res.flush_atc = 1'b1;
                    end
                end
            end
            OP_PFLUSH: begin
                if (sel == MODE_PLOAD) begin
                    res.status = ST_WALK;
                end else if (sel == MODE_FLUSH_ALL || sel == MODE_FLUSH_FC ||
                             sel == MODE_FLUSH_EA) begin
                    res.flush_atc = 1'b1;
                end else begin
                    res.status = ST_FLINE;
                end
            end
            OP_PMOVE_MMU: begin
                if (sel == REG_TC) begin
                    if (to_mem) begin
                        res.store_kind = SK_LONG;
                        res.store_hi   = tc_shadow;
                    end else if (fault) begin
                        res.status = ST_FAULT;
                    end else begin
                        tc_shadow     = hi;
                        enable_shadow = hi[31];
                        field_sum = {3'b0, hi[19:16]} + {3'b0, hi[23:20]} + {3'b0, hi[15:12]}
                                  + {3'b0, hi[11:8]} + {3'b0, hi[7:4]} + {3'b0, hi[3:0]};
                        // Bad layout with E set: committed, then disabled and flushed
                        if (enable_shadow &&
                            (field_sum != TC_FIELD_SUM || hi[23:20] < TC_PS_MIN)) begin
                            enable_shadow = 1'b0;
                            res.flush_atc = 1'b1;
                            res.status    = ST_CONFIG;
                        end else begin
                            res.flush_atc = !fd;
                        end
                    end
                end else if (sel == REG_SRP || sel == REG_CRP) begin
                    if (to_mem) begin
                        res.store_kind = SK_TWO;
                        {res.store_hi, res.store_lo} =
                            (sel == REG_SRP) ? srp_shadow : crp_shadow;
                    end else if (fault) begin
                        res.status = ST_FAULT;
                    end else begin
                        if (sel == REG_SRP) srp_shadow = {hi, lo};
                        else crp_shadow = {hi, lo};
                        // Invalid descriptor type flushes regardless of FD
                        if (hi[1:0] == DT_INVALID) begin
                            res.status    = ST_CONFIG;
                            res.flush_atc = 1'b1;
                        end else begin
                            res.flush_atc = !fd;
                        end
                    end
                end
            end
            OP_PMOVE_SR: begin
                // MMUSR load ignores the fault
                if (to_mem) begin
                    res.store_kind = SK_WORD;
                    res.store_hi   = {16'h0000, mmusr_shadow};
                end else begin
                    mmusr_shadow = hi[15:0];
                end
            end
            OP_PTEST: res.status = ST_WALK;
            default: ;
        endcase
        res.translation_enabled = enable_shadow;
        return res;
    endfunction

    // Predict on input transactions, compare on output transactions
    always @(posedge i_clk) begin : scoreboard
        t_out want;
        t_out got;
        if (!i_rst_n) begin
            tc_shadow     = '0;
            enable_shadow = 1'b0;
            srp_shadow    = '0;
            crp_shadow    = '0;
            tt0_shadow    = '0;
            tt1_shadow    = '0;
            mmusr_shadow  = '0;
            expected_results.delete();
            pending_count <= 0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                expected_results.push_back(execute_instr(i_in_data));
            end
            if (i_out_valid && i_out_ready) begin
                got = i_out_data;
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result, status", 32'(got.status), 32'h0);
                end else begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status)
                        report_mismatch("status", 32'(got.status), 32'(want.status));
                    if (got.store_kind !== want.store_kind)
                        report_mismatch("store_kind", 32'(got.store_kind), 32'(want.store_kind));
                    if (got.store_hi !== want.store_hi)
                        report_mismatch("store_hi", got.store_hi, want.store_hi);
                    if (got.store_lo !== want.store_lo)
                        report_mismatch("store_lo", got.store_lo, want.store_lo);
                    if (got.flush_atc !== want.flush_atc)
                        report_mismatch("flush_atc", 32'(got.flush_atc), 32'(want.flush_atc));
                    if (got.translation_enabled !== want.translation_enabled)
                        report_mismatch("translation_enabled", 32'(got.translation_enabled),
                                        32'(want.translation_enabled));
                end
                result_index++;
            end
            pending_count <= expected_results.size();
        end
    end

endmodule

FILE: tb/tb_pmmu_control_register_unit.sv
// Testbench top for the PMMU control register unit: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_pmmu_control_register_unit;
    import pcru_pkg::*;

    localparam int         QUIET_LIMIT    = 1000;
    localparam int         ITEM_COUNT     = 1200;
    localparam logic       DIR_TO_REG     = 1'b0;
    localparam logic       DIR_TO_MEM     = 1'b1;
    localparam logic       FD_CLEAR       = 1'b0;
    localparam logic       FD_SET         = 1'b1;
    localparam logic [2:0] OP_RESERVED_5  = 3'd5;
    localparam logic [2:0] OP_RESERVED_7  = 3'd7;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    t_in  i_data  = '0;
    logic i_ready = 1'b0;
    logic o_ready;
    logic o_valid;
    t_out o_data;

    int fail_count;
    int pending_count;
    int in_idle_pct  = 16;
    int out_idle_pct = 16;
    int quiet_cycles = 0;

    always #5 i_clk = ~i_clk;

    pmmu_control_register_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    pcru_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_in_data    (i_data),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_out_data   (o_data),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    // Result side back-pressure
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= out_idle_pct);
    end

    // Watchdog: too long without any transaction
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic t_in make_instr(input logic [2:0] op, input logic [2:0] sel,
                                       input logic to_mem, input logic fd,
                                       input logic [31:0] hi, input logic [31:0] lo,
                                       input logic fault);
        t_in item;
        logic [7:0] low_bits;
        low_bits            = 8'($urandom_range(0, 255));
        item.ext_word       = {op, sel, to_mem, fd, low_bits};
        item.operand_hi     = hi;
        item.operand_lo     = lo;
        item.operand_fault  = fault;
        return item;
    endfunction

    // Mostly well-formed instructions with random content, some raw noise
    function automatic t_in random_instr();
        t_in        item;
        logic [2:0] op;
        logic [2:0] sel;
        int         pick;
        int         ps;
        int         left;
        int         idx;
        int         fields[5];
        pick = $urandom_range(0, 99);
        if (pick < 40) op = OP_PMOVE_MMU;
        else if (pick < 55) op = OP_PMOVE_TT;
        else if (pick < 68) op = OP_PMOVE_SR;
        else if (pick < 85) op = OP_PFLUSH;
        else if (pick < 93) op = OP_PTEST;
        else op = 3'($urandom_range(OP_RESERVED_5, OP_RESERVED_7));
        sel = 3'($urandom_range(0, 7));
        if (op == OP_PMOVE_MMU && $urandom_range(0, 99) < 85) begin
            case ($urandom_range(0, 2))
                0: sel = REG_TC;
                1: sel = REG_SRP;
                default: sel = REG_CRP;
            endcase
        end else if (op == OP_PMOVE_TT && $urandom_range(0, 99) < 85) begin
            sel = $urandom_range(0, 1) ? REG_TT1 : REG_TT0;
        end
        item = make_instr(op, sel, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          $urandom, $urandom, ($urandom_range(0, 9) == 0));
        if (pick >= 95) item.ext_word = 16'($urandom);

        // TC loads: mostly legal layouts, some just off
        if (op == OP_PMOVE_MMU && sel == REG_TC && $urandom_range(0, 4) < 3) begin
            ps   = $urandom_range(8, 15);
            left = 32 - ps;
            foreach (fields[i]) fields[i] = 0;
            while (left > 0) begin
                idx = $urandom_range(0, 4);
                if (fields[idx] < 15) begin
                    fields[idx]++;
                    left--;
                end
            end
            item.operand_hi[31]    = 1'b1;
            item.operand_hi[23:20] = 4'(ps);
            item.operand_hi[19:16] = 4'(fields[0]);
            item.operand_hi[15:12] = 4'(fields[1]);
            item.operand_hi[11:8]  = 4'(fields[2]);
            item.operand_hi[7:4]   = 4'(fields[3]);
            item.operand_hi[3:0]   = 4'(fields[4]);
            if ($urandom_range(0, 3) == 0) begin
                if ($urandom_range(0, 1)) item.operand_hi[3:0] = item.operand_hi[3:0] + 4'd1;
                else item.operand_hi[23:20] = 4'($urandom_range(0, 7));
            end
        end

        // Root loads: invalid descriptor type now and then
        if (op == OP_PMOVE_MMU && (sel == REG_SRP || sel == REG_CRP) &&
            $urandom_range(0, 3) == 0) begin
            item.operand_hi[1:0] = DT_INVALID;
        end
        return item;
    endfunction

    // Present one transaction, with random idle cycles before it
    task automatic send_instr(input t_in item);
        while ($urandom_range(0, 99) < in_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= item;
        do @(posedge i_clk); while (!o_ready);
    endtask

    initial begin : stimulus
        int mode;
        int n;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: stores from reset, TC layouts, roots, faults, all flush modes
        send_instr(make_instr(OP_PMOVE_MMU, REG_TC, DIR_TO_MEM, FD_CLEAR, '1, '1, 1'b1));
        send_instr(make_instr(OP_PMOVE_MMU, REG_TC, DIR_TO_REG, FD_CLEAR,
                              32'h80C0AA00, 32'h0, 1'b0));
        send_instr(make_instr(OP_PMOVE_MMU, REG_TC, DIR_TO_REG, FD_SET,
                              32'h8080F900, 32'h0, 1'b0));
        send_instr(make_instr(OP_PMOVE_MMU, REG_TC, DIR_TO_REG, FD_SET,
                              32'h80C0AA01, 32'h0, 1'b0));
        send_instr(make_instr(OP_PMOVE_MMU, REG_TC, DIR_TO_REG, FD_SET,
                              32'h807FA000, 32'h0, 1'b0));
        send_instr(make_instr(OP_PMOVE_MMU, REG_TC, DIR_TO_REG, FD_CLEAR,
                              32'h7FFFFFFF, 32'h0, 1'b0));
        send_instr(make_instr(OP_PMOVE_MMU, REG_TC, DIR_TO_MEM, FD_CLEAR, '0, '0, 1'b0));
        send_instr(make_instr(OP_PMOVE_MMU, REG_TC, DIR_TO_REG, FD_CLEAR,
                              32'hFFFFFFFF, 32'h0, 1'b0));
        send_instr(make_instr(OP_PMOVE_MMU, REG_SRP, DIR_TO_REG, FD_SET,
                              32'h12345678, 32'h9ABCDEF0, 1'b0));
        send_instr(make_instr(OP_PMOVE_MMU, REG_CRP, DIR_TO_REG, FD_SET,
                              32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0));
        send_instr(make_instr(OP_PMOVE_MMU, REG_CRP, DIR_TO_MEM, FD_CLEAR, '0, '0, 1'b0));
        send_instr(make_instr(OP_PMOVE_MMU, REG_SRP, DIR_TO_MEM, FD_CLEAR, '0, '0, 1'b1));
        send_instr(make_instr(OP_PMOVE_TT, REG_TT0, DIR_TO_REG, FD_CLEAR,
                              32'hFFFFFFFF, 32'h0, 1'b0));
        send_instr(make_instr(OP_PMOVE_TT, REG_TT0, DIR_TO_MEM, FD_CLEAR, '0, '0, 1'b0));
        send_instr(make_instr(OP_PMOVE_SR, 3'd0, DIR_TO_REG, FD_CLEAR,
                              32'hFFFFFFFF, 32'h0, 1'b1));
        send_instr(make_instr(OP_PMOVE_SR, 3'd0, DIR_TO_MEM, FD_CLEAR, '0, '0, 1'b0));
        // Faulted loads change nothing
        send_instr(make_instr(OP_PMOVE_MMU, REG_TC, DIR_TO_REG, FD_CLEAR,
                              32'h80C0AA00, 32'h0, 1'b1));
        send_instr(make_instr(OP_PMOVE_MMU, REG_SRP, DIR_TO_REG, FD_CLEAR,
                              32'h00000003, 32'h0, 1'b1));
        send_instr(make_instr(OP_PMOVE_TT, REG_TT1, DIR_TO_REG, FD_CLEAR,
                              32'hA5A5A5A5, 32'h0, 1'b1));
        for (mode = 0; mode < 8; mode++) begin
            send_instr(make_instr(OP_PFLUSH, 3'(mode), 1'($urandom_range(0, 1)),
                                  1'($urandom_range(0, 1)), $urandom, $urandom,
                                  1'($urandom_range(0, 1))));
        end
        send_instr(make_instr(OP_PTEST, 3'd7, DIR_TO_MEM, FD_SET, '1, '1, 1'b1));
        send_instr(make_instr(OP_RESERVED_7, 3'd7, DIR_TO_MEM, FD_SET, '1, '1, 1'b1));

        // Random part, with a stretch of full throughput in the middle
        for (n = 0; n < ITEM_COUNT; n++) begin
            if (n == 500) begin
                in_idle_pct  = 0;
                out_idle_pct <= 0;
            end
            if (n == 800) begin
                in_idle_pct  = 16;
                out_idle_pct <= 16;
            end
            send_instr(random_instr());
        end
        i_valid <= 1'b0;
        @(posedge i_clk);

        // Drain, then let the pipeline settle
        while (pending_count != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

FILE: pmmu_control_register_unit.f
hw/rtl/pcru_pkg.sv
hw/rtl/pcru_front.sv
hw/rtl/pcru_queue.sv
hw/rtl/pcru_back.sv
hw/rtl/pmmu_control_register_unit.sv
tb/pcru_result_checker.sv
tb/tb_pmmu_control_register_unit.sv
